@@ rtl/wts_pkg.sv @@
package wts_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int MAX_STEPS = 24;
	localparam int VW = 36;
	localparam int ZW = 32;
	localparam int PW = VW + 14;
	localparam int RAD_W = 46;
	localparam int SQ_STEPS = 23;
	localparam int SQSUM_W = 27;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
	localparam int FULL_TURN = 3600;
	localparam int HALF_TURN = 1800;
	localparam int QUARTER_TURN = 900;
	localparam int SPEED_MAX = 16383;

	localparam int ST_MUL = CORDIC_STEPS + 1;
	localparam int ST_RAD = CORDIC_STEPS + 2;
	localparam int ST_VEC = CORDIC_STEPS + 3;
	localparam int ST_DIR = 2 * CORDIC_STEPS + 3;
	localparam int ST_SQ = 2 * CORDIC_STEPS + 4;
	localparam int ST_LAST = 2 * CORDIC_STEPS + 3 + SQ_STEPS;

	typedef struct packed {
		logic [11:0]            trk;
		logic [12:0]            gs;
		logic [SQSUM_W-1:0]     sqsum;
		logic signed [VW-1:0]   x0;
		logic signed [ZW-1:0]   z0;
	} wts_item_t;

	typedef struct packed {
		logic [11:0]            trk;
		logic [12:0]            gs;
		logic [SQSUM_W-1:0]     sqsum;
		logic signed [VW-1:0]   x;
		logic signed [VW-1:0]   y;
		logic signed [ZW-1:0]   z;
		logic signed [PW-1:0]   prod;
		logic                   zero;
		logic [RAD_W-1:0]       rad;
		logic [RAD_W-1:0]       res;
		logic [11:0]            dir;
	} wts_stage_t;

	function automatic logic signed [ZW-1:0] atan_val(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 32'sd29491200;
			1: v = 32'sd17409672;
			2: v = 32'sd9198793;
			3: v = 32'sd4669451;
			4: v = 32'sd2343786;
			5: v = 32'sd1173036;
			6: v = 32'sd586661;
			7: v = 32'sd293348;
			8: v = 32'sd146676;
			9: v = 32'sd73339;
			10: v = 32'sd36669;
			11: v = 32'sd18335;
			12: v = 32'sd9167;
			13: v = 32'sd4584;
			14: v = 32'sd2292;
			15: v = 32'sd1146;
			16: v = 32'sd573;
			17: v = 32'sd286;
			18: v = 32'sd143;
			19: v = 32'sd72;
			20: v = 32'sd36;
			21: v = 32'sd18;
			22: v = 32'sd9;
			23: v = 32'sd4;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/wind_triangle_solver.sv @@
// Wind triangle solver: from track/ground speed and heading/airspeed it
// returns wind speed and the direction the wind comes from.
// Input channel: in_valid/in_ready with track_angle, ground_speed,
// heading_angle, air_speed (tenths of a degree, tenths of km/h).
// Output channel: out_valid/out_ready with wind_speed, wind_direction.
// Throughput: one item per cycle, sustained while out_ready stays high.
// Path from acceptance to out_valid: 2 front stages, queue, the back
// entry register, CORDIC_STEPS rotation stages, two setup stages,
// CORDIC_STEPS vectoring stages, one direction stage, 23 square root
// stages and the output register.
// The front stages feed a four-entry queue; the back pipeline advances
// only when its output register is empty or being taken, so a stalled
// receiver freezes the back end while the front keeps filling the queue;
// in_ready drops once the queue is full and the second front stage holds an item.
// Reset clears all valid flags and the queue; no item is in flight after
// reset and the block accepts items on the first cycle after it.
module wind_triangle_solver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] track_angle,
	input  logic [12:0] ground_speed,
	input  logic [11:0] heading_angle,
	input  logic [12:0] air_speed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [13:0] wind_speed,
	output logic [11:0] wind_direction
);

	logic               push, full, pop, nempty;
	wts_pkg::wts_item_t push_item, head;

	wts_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.track_angle(track_angle), .ground_speed(ground_speed),
		.heading_angle(heading_angle), .air_speed(air_speed),
		.push(push), .push_item(push_item), .full(full)
	);

	wts_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item), .full(full),
		.pop(pop), .nempty(nempty), .head(head)
	);

	wts_back u_back (
		.clk(clk), .arst_n(arst_n),
		.nempty(nempty), .head(head), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.wind_speed(wind_speed), .wind_direction(wind_direction)
	);

endmodule

@@ rtl/wts_front.sv @@
module wts_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [11:0]         track_angle,
	input  logic [12:0]         ground_speed,
	input  logic [11:0]         heading_angle,
	input  logic [12:0]         air_speed,
	output logic                push,
	output wts_pkg::wts_item_t  push_item,
	input  logic                full
);

	logic               vld_s1, vld_s2, fe;
	logic [11:0]        trk_c, hdg_c;
	logic signed [12:0] wca_raw, wca_c;
	logic [11:0]        trk_s1;
	logic [12:0]        gs_s1, air_s1;
	logic signed [12:0] wca_s1;
	logic [25:0]        sqa_s1, sqg_s1;
	logic signed [12:0] zq;
	logic               neg;
	logic [42:0]        pa;
	logic [28:0]        xa;
	wts_pkg::wts_item_t item_s2;

	assign fe = !vld_s2 || !full;
	assign in_ready = fe;
	assign push = vld_s2 && !full;
	assign push_item = item_s2;

	always_comb begin
		trk_c = (track_angle >= 12'(wts_pkg::FULL_TURN)) ?
			track_angle - 12'(wts_pkg::FULL_TURN) : track_angle;
		hdg_c = (heading_angle >= 12'(wts_pkg::FULL_TURN)) ?
			heading_angle - 12'(wts_pkg::FULL_TURN) : heading_angle;
		wca_raw = $signed({1'b0, hdg_c}) - $signed({1'b0, trk_c});
		if (wca_raw > 13'sd1800) begin
			wca_c = wca_raw - 13'(wts_pkg::FULL_TURN);
		end else if (wca_raw <= -13'sd1800) begin
			wca_c = wca_raw + 13'(wts_pkg::FULL_TURN);
		end else begin
			wca_c = wca_raw;
		end
	end

	// fold the angle into +-90 degrees and flip the start vector instead
	always_comb begin
		neg = 1'b0;
		zq = wca_s1;
		if (wca_s1 > 13'(wts_pkg::QUARTER_TURN)) begin
			neg = 1'b1;
			zq = wca_s1 - 13'(wts_pkg::HALF_TURN);
		end else if (wca_s1 < -13'(wts_pkg::QUARTER_TURN)) begin
			neg = 1'b1;
			zq = wca_s1 + 13'(wts_pkg::HALF_TURN);
		end
		pa = 43'(air_s1) * 43'(wts_pkg::INV_GAIN_Q30);
		xa = pa[42:14];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (fe) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			trk_s1 <= trk_c;
			gs_s1 <= ground_speed;
			air_s1 <= air_speed;
			wca_s1 <= wca_c;
			sqa_s1 <= 26'(air_speed) * 26'(air_speed);
			sqg_s1 <= 26'(ground_speed) * 26'(ground_speed);
			item_s2.trk <= trk_s1;
			item_s2.gs <= gs_s1;
			item_s2.sqsum <= wts_pkg::SQSUM_W'(sqa_s1) + wts_pkg::SQSUM_W'(sqg_s1);
			item_s2.x0 <= neg ? -wts_pkg::VW'(xa) : wts_pkg::VW'(xa);
			item_s2.z0 <= wts_pkg::ZW'($signed({zq, 16'b0}));
		end
	end

endmodule

@@ rtl/wts_queue.sv @@
module wts_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wts_pkg::wts_item_t  push_item,
	output logic                full,
	input  logic                pop,
	output logic                nempty,
	output wts_pkg::wts_item_t  head
);

	wts_pkg::wts_item_t               mem_q [wts_pkg::QUEUE_DEPTH];
	logic [wts_pkg::QPTR_W-1:0]       wr_q, rd_q;
	logic [wts_pkg::QCNT_W-1:0]       cnt_q;

	assign full = cnt_q == wts_pkg::QCNT_W'(wts_pkg::QUEUE_DEPTH);
	assign nempty = cnt_q != '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

@@ rtl/wts_back.sv @@
module wts_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                nempty,
	input  wts_pkg::wts_item_t  head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [13:0]         wind_speed,
	output logic [11:0]         wind_direction
);

	wts_pkg::wts_stage_t        pl [wts_pkg::ST_LAST + 1];
	logic [wts_pkg::ST_LAST:0]  vl;
	logic                       en, out_valid_q;
	logic [13:0]                spd_q;
	logic [11:0]                dir_q;
	logic [wts_pkg::RAD_W-1:0]  rnd, shf;

	assign en = !out_valid_q || out_ready;
	assign pop = en && nempty;
	assign out_valid = out_valid_q;
	assign wind_speed = spd_q;
	assign wind_direction = dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vl <= {vl[wts_pkg::ST_LAST-1:0], nempty};
			out_valid_q <= vl[wts_pkg::ST_LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl[0].trk <= head.trk;
			pl[0].gs <= head.gs;
			pl[0].sqsum <= head.sqsum;
			pl[0].x <= head.x0;
			pl[0].y <= '0;
			pl[0].z <= head.z0;
			pl[0].prod <= '0;
			pl[0].zero <= 1'b0;
			pl[0].rad <= '0;
			pl[0].res <= '0;
			pl[0].dir <= '0;
		end
	end

	// rotation: air vector turned by the correction angle
	for (genvar k = 1; k <= wts_pkg::CORDIC_STEPS; k++) begin : g_rot
		wts_pkg::wts_stage_t c;
		always_comb begin
			c = pl[k-1];
			if (!pl[k-1].z[wts_pkg::ZW-1]) begin
				c.x = pl[k-1].x - (pl[k-1].y >>> (k - 1));
				c.y = pl[k-1].y + (pl[k-1].x >>> (k - 1));
				c.z = pl[k-1].z - wts_pkg::atan_val(k - 1);
			end else begin
				c.x = pl[k-1].x + (pl[k-1].y >>> (k - 1));
				c.y = pl[k-1].y - (pl[k-1].x >>> (k - 1));
				c.z = pl[k-1].z + wts_pkg::atan_val(k - 1);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pl[k] <= c;
			end
		end
	end

	// wind vector setup and cross term for the radicand
	if (1) begin : g_mul
		wts_pkg::wts_stage_t c;
		logic signed [wts_pkg::VW-1:0] vx;
		always_comb begin
			c = pl[wts_pkg::ST_MUL-1];
			c.prod = $signed(pl[wts_pkg::ST_MUL-1].x) * $signed({1'b0, pl[wts_pkg::ST_MUL-1].gs});
			vx = pl[wts_pkg::ST_MUL-1].x - $signed(wts_pkg::VW'({pl[wts_pkg::ST_MUL-1].gs, 16'b0}));
			c.zero = (vx == '0) && (pl[wts_pkg::ST_MUL-1].y == '0);
			if (vx[wts_pkg::VW-1]) begin
				c.x = -vx;
				c.y = -pl[wts_pkg::ST_MUL-1].y;
				c.z = wts_pkg::ZW'($signed({12'(wts_pkg::HALF_TURN), 16'b0}));
			end else begin
				c.x = vx;
				c.z = '0;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pl[wts_pkg::ST_MUL] <= c;
			end
		end
	end

	if (1) begin : g_rad
		wts_pkg::wts_stage_t c;
		logic signed [wts_pkg::PW:0] r;
		always_comb begin
			c = pl[wts_pkg::ST_RAD-1];
			r = $signed({{(wts_pkg::PW + 1 - wts_pkg::SQSUM_W - 16){1'b0}},
				pl[wts_pkg::ST_RAD-1].sqsum, 16'b0}) - $signed({pl[wts_pkg::ST_RAD-1].prod, 1'b0});
			// clamp a negative radicand
			c.rad = r[wts_pkg::PW] ? '0 : r[wts_pkg::RAD_W-1:0];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pl[wts_pkg::ST_RAD] <= c;
			end
		end
	end

	// vectoring: angle of the wind vector
	for (genvar k = 0; k < wts_pkg::CORDIC_STEPS; k++) begin : g_vec
		wts_pkg::wts_stage_t c;
		always_comb begin
			c = pl[wts_pkg::ST_VEC+k-1];
			if (!pl[wts_pkg::ST_VEC+k-1].y[wts_pkg::VW-1]) begin
				c.x = pl[wts_pkg::ST_VEC+k-1].x + (pl[wts_pkg::ST_VEC+k-1].y >>> k);
				c.y = pl[wts_pkg::ST_VEC+k-1].y - (pl[wts_pkg::ST_VEC+k-1].x >>> k);
				c.z = pl[wts_pkg::ST_VEC+k-1].z + wts_pkg::atan_val(k);
			end else begin
				c.x = pl[wts_pkg::ST_VEC+k-1].x - (pl[wts_pkg::ST_VEC+k-1].y >>> k);
				c.y = pl[wts_pkg::ST_VEC+k-1].y + (pl[wts_pkg::ST_VEC+k-1].x >>> k);
				c.z = pl[wts_pkg::ST_VEC+k-1].z - wts_pkg::atan_val(k);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pl[wts_pkg::ST_VEC+k] <= c;
			end
		end
	end

	if (1) begin : g_dir
		wts_pkg::wts_stage_t c;
		logic signed [wts_pkg::ZW-1:0] t;
		logic signed [15:0] d;
		always_comb begin
			c = pl[wts_pkg::ST_DIR-1];
			t = $signed(wts_pkg::ZW'({pl[wts_pkg::ST_DIR-1].trk, 16'b0}))
				+ (pl[wts_pkg::ST_DIR-1].zero ? '0 : pl[wts_pkg::ST_DIR-1].z)
				+ $signed(wts_pkg::ZW'(32768));
			d = 16'(t >>> 16);
			if (d < 0) begin
				d = d + 16'(wts_pkg::FULL_TURN);
			end else if (d >= 16'(wts_pkg::FULL_TURN)) begin
				d = d - 16'(wts_pkg::FULL_TURN);
			end
			c.dir = d[11:0];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pl[wts_pkg::ST_DIR] <= c;
			end
		end
	end

	// square root, one result bit a stage
	for (genvar j = 0; j < wts_pkg::SQ_STEPS; j++) begin : g_sq
		localparam logic [wts_pkg::RAD_W-1:0] BITV =
			wts_pkg::RAD_W'(1) << (2 * (wts_pkg::SQ_STEPS - 1 - j));
		wts_pkg::wts_stage_t c;
		always_comb begin
			c = pl[wts_pkg::ST_SQ+j-1];
			if (pl[wts_pkg::ST_SQ+j-1].rad >= pl[wts_pkg::ST_SQ+j-1].res + BITV) begin
				c.rad = pl[wts_pkg::ST_SQ+j-1].rad - (pl[wts_pkg::ST_SQ+j-1].res + BITV);
				c.res = (pl[wts_pkg::ST_SQ+j-1].res >> 1) + BITV;
			end else begin
				c.res = pl[wts_pkg::ST_SQ+j-1].res >> 1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pl[wts_pkg::ST_SQ+j] <= c;
			end
		end
	end

	always_comb begin
		rnd = pl[wts_pkg::ST_LAST].res + wts_pkg::RAD_W'(128);
		shf = rnd >> 8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spd_q <= (shf > wts_pkg::RAD_W'(wts_pkg::SPEED_MAX)) ?
				14'(wts_pkg::SPEED_MAX) : shf[13:0];
			dir_q <= pl[wts_pkg::ST_LAST].dir;
		end
	end

endmodule

@@ rtl/wts_checker.sv @@
module wts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [13:0] wind_speed,
	input logic [11:0] wind_direction
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(wind_speed)
			&& $stable(wind_direction))
		else $error("output item changed while stalled");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> wind_direction < 12'd3600)
		else $error("wind direction out of range");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid right after reset");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid && in_ready)
		else $error("output valid or input stalled right after reset");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input item dropped while stalled");

endmodule

bind wind_triangle_solver wts_checker u_wts_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.wind_speed(wind_speed), .wind_direction(wind_direction)
);

@@ tb/wind_triangle_solver_tb.sv @@
`timescale 1ns / 100ps

module wind_triangle_solver_tb;

	localparam int N_RANDOM = 1000;
	localparam int CALM_TAIL = 120;
	localparam int DRAIN_CYCLES = 2 * wts_pkg::CORDIC_STEPS + 60;

	typedef longint unsigned u64_t;

	typedef struct {
		logic [11:0] trk;
		logic [12:0] gs;
		logic [11:0] hdg;
		logic [12:0] air;
	} nav_sample_t;

	typedef struct {
		logic [13:0] spd;
		logic [11:0] dir;
	} wind_t;

	localparam longint ARC_TAB [wts_pkg::MAX_STEPS] = '{
		29491200, 17409672, 9198793, 4669451, 2343786, 1173036, 586661, 293348,
		146676, 73339, 36669, 18335, 9167, 4584, 2292, 1146,
		573, 286, 143, 72, 36, 18, 9, 4
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [11:0] track_angle;
	logic [12:0] ground_speed;
	logic [11:0] heading_angle;
	logic [12:0] air_speed;
	logic        out_valid;
	logic        out_ready;
	logic [13:0] wind_speed;
	logic [11:0] wind_direction;

	nav_sample_t pending_samples[$];
	wind_t       wind_expected[$];
	int          err_count = 0;
	int          sent_count;
	int          seen_count;
	int          send_idle;
	int          take_idle;
	int          total_items;
	bit          calm = 1'b0;

	wind_triangle_solver u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.track_angle    (track_angle),
		.ground_speed   (ground_speed),
		.heading_angle  (heading_angle),
		.air_speed      (air_speed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.wind_speed     (wind_speed),
		.wind_direction (wind_direction)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int n_stages();
		int n;
		n = wts_pkg::CORDIC_STEPS;
		if (n > wts_pkg::MAX_STEPS) n = wts_pkg::MAX_STEPS;
		if (n < 0) n = 0;
		return n;
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic wind_t solve_wind(nav_sample_t s);
		wind_t w;
		longint trk, gs, hdg, air, wca, x, y, z, dx, dy, vx, vy, ang, dir, rad, spd;
		longint unsigned ux;
		trk = longint'(s.trk) % wts_pkg::FULL_TURN;
		gs  = longint'(s.gs);
		hdg = longint'(s.hdg) % wts_pkg::FULL_TURN;
		air = longint'(s.air);
		wca = hdg - trk;
		if (wca > wts_pkg::HALF_TURN) wca -= wts_pkg::FULL_TURN;
		else if (wca <= -wts_pkg::HALF_TURN) wca += wts_pkg::FULL_TURN;

		ux = ((u64_t'(air) << 16) * 64'd652032874) >> 30;
		x = longint'(ux);
		y = 0;
		if (wca > wts_pkg::QUARTER_TURN) begin
			x = -x;
			z = (wca - wts_pkg::HALF_TURN) * 65536;
		end else if (wca < -wts_pkg::QUARTER_TURN) begin
			x = -x;
			z = (wca + wts_pkg::HALF_TURN) * 65536;
		end else begin
			z = wca * 65536;
		end
		// rotate the air vector by the correction angle
		for (int i = 0; i < n_stages(); i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARC_TAB[i];
			end else begin
				x += dx; y -= dy; z += ARC_TAB[i];
			end
		end

		// vector back to an angle
		vy = y;
		vx = x - gs * 65536;
		ang = 0;
		if (vx != 0 || vy != 0) begin
			if (vx < 0) begin
				vx = -vx;
				vy = -vy;
				ang = longint'(wts_pkg::HALF_TURN) * 65536;
			end
			for (int i = 0; i < n_stages(); i++) begin
				dx = vy >>> i;
				dy = vx >>> i;
				if (vy >= 0) begin
					vx += dx; vy -= dy; ang += ARC_TAB[i];
				end else begin
					vx -= dx; vy += dy; ang -= ARC_TAB[i];
				end
			end
		end
		dir = ((trk * 65536 + ang + 32768) >>> 16) % wts_pkg::FULL_TURN;
		if (dir < 0) dir += wts_pkg::FULL_TURN;

		rad = (air * air + gs * gs) * 65536 - 2 * x * gs;
		if (rad < 0) rad = 0;
		spd = longint'((root64(u64_t'(rad)) + 128) >> 8);
		if (spd > wts_pkg::SPEED_MAX) spd = wts_pkg::SPEED_MAX;
		w.spd = spd[13:0];
		w.dir = dir[11:0];
		return w;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			track_angle   <= '0;
			ground_speed  <= '0;
			heading_angle <= '0;
			air_speed     <= '0;
			send_idle     <= 0;
			sent_count    <= 0;
		end else begin
			nav_sample_t s;
			if (in_valid && in_ready) begin
				s.trk = track_angle;
				s.gs  = ground_speed;
				s.hdg = heading_angle;
				s.air = air_speed;
				wind_expected.insert(wind_expected.size(), solve_wind(s));
				sent_count <= sent_count + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_idle > 0) begin
					in_valid  <= 1'b0;
					send_idle <= send_idle - 1;
				end else if (pending_samples.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					in_valid  <= 1'b0;
					send_idle <= $urandom_range(0, 8);
				end else begin
					s = pending_samples[0];
					pending_samples.delete(0);
					track_angle   <= s.trk;
					ground_speed  <= s.gs;
					heading_angle <= s.hdg;
					air_speed     <= s.air;
					in_valid      <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			take_idle  <= 0;
			seen_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				wind_t w;
				seen_count <= seen_count + 1;
				if (wind_expected.size() == 0) begin
					$error("unexpected item: wind_speed %0d wind_direction %0d",
						wind_speed, wind_direction);
					err_count++;
				end else begin
					w = wind_expected[0];
					wind_expected.delete(0);
					if (wind_speed !== w.spd) begin
						$error("wind_speed: expected %0d, actual %0d", w.spd, wind_speed);
						err_count++;
					end
					if (wind_direction !== w.dir) begin
						$error("wind_direction: expected %0d, actual %0d",
							w.dir, wind_direction);
						err_count++;
					end
				end
			end
			if (take_idle > 0) begin
				out_ready <= 1'b0;
				take_idle <= take_idle - 1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				take_idle <= $urandom_range(0, 8);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// drop idling for the tail of the run
	always @(posedge clk) begin
		if (pending_samples.size() < CALM_TAIL && total_items > 0)
			calm <= 1'b1;
	end

	task automatic add_sample(int trk, int gs, int hdg, int air);
		nav_sample_t s;
		s.trk = 12'(trk);
		s.gs  = 13'(gs);
		s.hdg = 12'(hdg);
		s.air = 13'(air);
		pending_samples.insert(pending_samples.size(), s);
	endtask

	initial begin
		total_items = 0;
		arst_n      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// extremes, wraparound of the correction angle, out-of-range angles
		add_sample(0, 0, 0, 0);
		add_sample(4095, 8191, 4095, 8191);
		add_sample(3599, 8191, 3599, 8191);
		add_sample(0, 8191, 1800, 8191);
		add_sample(1800, 8191, 0, 8191);
		add_sample(0, 1000, 900, 1000);
		add_sample(900, 1000, 0, 1000);
		add_sample(0, 500, 901, 700);
		add_sample(3599, 500, 0, 700);
		add_sample(0, 500, 3599, 700);
		add_sample(3600, 1234, 4000, 2345);
		add_sample(4095, 0, 3700, 4096);
		// no air vector and no ground speed: angle term is zero
		add_sample(1234, 0, 2222, 0);
		add_sample(100, 2000, 100, 2000);
		add_sample(2500, 4000, 2500, 0);
		add_sample(2500, 0, 300, 4000);
		add_sample(1799, 8191, 3599, 8191);
		add_sample(1, 1, 1801, 1);
		add_sample(2048, 4096, 1024, 2730);
		add_sample(1365, 5461, 2730, 5461);

		for (int i = 0; i < N_RANDOM; i++) begin
			int sel;
			sel = $urandom_range(0, 9);
			if (sel == 0)
				add_sample($urandom_range(0, 4095), $urandom_range(0, 8191),
					$urandom_range(0, 4095), $urandom_range(0, 8191));
			else if (sel == 1)
				add_sample($urandom_range(0, 3599), $urandom_range(0, 8191),
					$urandom_range(0, 3599), 0);
			else if (sel == 2)
				add_sample($urandom_range(0, 3599), $urandom_range(7000, 8191),
					$urandom_range(0, 3599), $urandom_range(7000, 8191));
			else
				add_sample($urandom_range(0, 3599), $urandom_range(0, 3000),
					$urandom_range(0, 3599), $urandom_range(300, 3000));
		end
		total_items = pending_samples.size();

		wait (pending_samples.size() == 0 && !in_valid);
		wait (wind_expected.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d navigation samples through the solver, %0d wind results checked",
			sent_count, seen_count);
		$display("including angle wrap, out-of-range angles, zero vectors and full-scale speeds");
		if (err_count == 0 && wind_expected.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
